// File: hdl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Types, widths and step functions for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int EPS_BITS  = 16;

  localparam int MAG_BITS  = COEF_BITS;          // |coef| including the most negative value
  localparam int PROD_BITS = 2 * MAG_BITS;       // b*b, a*c
  localparam int DISC_BITS = PROD_BITS + 2;      // b*b + 4ac
  localparam int ROOT_BITS = DISC_BITS / 2;      // sqrt digits, one per stage
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int SREM_BITS = ROOT_BITS + 1;
  localparam int NUM_BITS  = ROOT_BITS;          // |b| +- sqrt(D)
  localparam int DIV_BITS  = MAG_BITS + 1;       // 2|a|
  localparam int QUO_BITS  = NUM_BITS + FRAC_BITS;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
    logic signed [COEF_BITS-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic [1:0]                  root_count;
    logic signed [COEF_BITS-1:0] root_first;
    logic signed [COEF_BITS-1:0] root_second;
    logic                        overflow;
  } result_t;

  // carried alongside the square root
  typedef struct packed {
    logic [1:0]          count;
    logic                nsign;
    logic [MAG_BITS-1:0] nmag;
    logic                dsign;
    logic [DIV_BITS-1:0] dmag;
  } ctx_t;

  typedef struct packed {
    logic                 valid;
    ctx_t                 ctx;
    logic [RAD_BITS-1:0]  rad;
    logic [SREM_BITS-1:0] rem;
    logic [ROOT_BITS-1:0] root;
  } sq_stage_t;

  typedef struct packed {
    logic                valid;
    logic [1:0]          count;
    logic                neg1;
    logic                neg2;
    logic [DIV_BITS-1:0] dmag;
    logic [QUO_BITS-1:0] num1;
    logic [QUO_BITS-1:0] num2;
    logic [DIV_BITS-1:0] rem1;
    logic [DIV_BITS-1:0] rem2;
    logic [QUO_BITS-1:0] quo1;
    logic [QUO_BITS-1:0] quo2;
  } dv_stage_t;

  // one digit of the restoring square root
  function automatic sq_stage_t sq_step(input sq_stage_t s);
    sq_stage_t              r;
    logic [SREM_BITS+1:0]   tmp;
    logic [SREM_BITS+1:0]   trial;
    r     = s;
    tmp   = {s.rem, s.rad[RAD_BITS-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[RAD_BITS-3:0], 2'b00};
    if (tmp >= trial) begin
      r.rem  = SREM_BITS'(tmp - trial);
      r.root = {s.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      r.rem  = SREM_BITS'(tmp);
      r.root = {s.root[ROOT_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of a restoring divide
  function automatic logic [DIV_BITS:0] div_bit(input logic [DIV_BITS-1:0] rem,
                                                input logic                nbit,
                                                input logic [DIV_BITS-1:0] d);
    logic [DIV_BITS:0] tmp;
    tmp = {rem, nbit};
    if (tmp >= {1'b0, d}) begin
      return {DIV_BITS'(tmp - {1'b0, d}), 1'b1};
    end
    return {DIV_BITS'(tmp), 1'b0};
  endfunction

  function automatic dv_stage_t dv_step(input dv_stage_t s);
    dv_stage_t         r;
    logic [DIV_BITS:0] o1;
    logic [DIV_BITS:0] o2;
    r      = s;
    o1     = div_bit(s.rem1, s.num1[QUO_BITS-1], s.dmag);
    o2     = div_bit(s.rem2, s.num2[QUO_BITS-1], s.dmag);
    r.rem1 = o1[DIV_BITS:1];
    r.rem2 = o2[DIV_BITS:1];
    r.quo1 = {s.quo1[QUO_BITS-2:0], o1[0]};
    r.quo2 = {s.quo2[QUO_BITS-2:0], o2[0]};
    r.num1 = {s.num1[QUO_BITS-2:0], 1'b0};
    r.num2 = {s.num2[QUO_BITS-2:0], 1'b0};
    return r;
  endfunction

  // sign-magnitude sum, zero is positive; returns {sign, mag}
  function automatic logic [NUM_BITS:0] sm_add(input logic s1, input logic [NUM_BITS-1:0] m1,
                                               input logic s2, input logic [NUM_BITS-1:0] m2);
    logic                rs;
    logic [NUM_BITS-1:0] rm;
    if (s1 == s2) begin
      rs = s1;
      rm = m1 + m2;
    end else if (m1 >= m2) begin
      rs = s1;
      rm = m1 - m2;
    end else begin
      rs = s2;
      rm = m2 - m1;
    end
    if (rm == '0) rs = 1'b0;
    return {rs, rm};
  endfunction

  // saturate and apply sign; returns {ovf, value}
  function automatic logic [COEF_BITS:0] sat_root(input logic neg,
                                                  input logic [QUO_BITS-1:0] q);
    logic [QUO_BITS-1:0]  limit;
    logic [COEF_BITS-1:0] v;
    logic                 ovf;
    limit = neg ? (QUO_BITS'(1) << (COEF_BITS-1)) : ((QUO_BITS'(1) << (COEF_BITS-1)) - 1'b1);
    ovf   = q > limit;
    v     = ovf ? limit[COEF_BITS-1:0] : q[COEF_BITS-1:0];
    return {ovf, neg ? COEF_BITS'(~v + 1'b1) : v};
  endfunction

endpackage

// File: hdl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Fixed-point roots of a*x^2 + b*x + c = 0, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  signals                        direction
//  input    start, busy, coef              in (busy always low)
//  config   cfg_valid, cfg_ready, cfg_data in (cfg_ready always high)
//  result   done, result                   out, one cycle per beat
//
//  One beat accepted per cycle, one result per beat, in order.
//  The square root resolves one digit per stage and the two dividers one
//  quotient bit per stage; the result register follows the last divider stage.
//  rst clears the stage valid bits and sets epsilon to 1.
//  The receiver cannot stall, so the pipeline never halts.
module quadratic_root_solver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  qrs_pkg::coef_t                 coef,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qrs_pkg::EPS_BITS-1:0]   cfg_data,
  output logic                           done,
  output qrs_pkg::result_t               result
);
  import qrs_pkg::*;

  logic [EPS_BITS-1:0] epsilon;

  // stage 1: magnitudes and signs
  logic                v1;
  logic [MAG_BITS-1:0] ma, mb, mc;
  logic                na, nb, nc;
  // stage 2: products
  logic                v2;
  logic [PROD_BITS-1:0] bb, ac;
  logic [MAG_BITS-1:0] ma2, mb2, mc2;
  logic                na2, nb2, nc2;

  sq_stage_t sq [ROOT_BITS+1];
  dv_stage_t dv [QUO_BITS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_BITS'(1);
    end else if (cfg_valid) begin
      epsilon <= cfg_data;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    ma <= coef.coef_a[COEF_BITS-1] ? MAG_BITS'(-coef.coef_a) : MAG_BITS'(coef.coef_a);
    mb <= coef.coef_b[COEF_BITS-1] ? MAG_BITS'(-coef.coef_b) : MAG_BITS'(coef.coef_b);
    mc <= coef.coef_c[COEF_BITS-1] ? MAG_BITS'(-coef.coef_c) : MAG_BITS'(coef.coef_c);
    na <= coef.coef_a[COEF_BITS-1];
    nb <= coef.coef_b[COEF_BITS-1];
    nc <= coef.coef_c[COEF_BITS-1];
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    bb  <= mb * mb;
    ac  <= ma * mc;
    ma2 <= ma;
    mb2 <= mb;
    mc2 <= mc;
    na2 <= na;
    nb2 <= nb;
    nc2 <= nc;
  end

  // stage 3: discriminant and case selection
  logic                 za, zb, zc;
  logic [DISC_BITS-1:0] bbx, ac4, dmag;
  logic                 dneg;
  logic                 dsmall;
  sq_stage_t            sq_in;

  always_comb begin
    za   = (ma2 == '0) || (ma2 < MAG_BITS'(epsilon));
    zb   = (mb2 == '0) || (mb2 < MAG_BITS'(epsilon));
    zc   = (mc2 == '0) || (mc2 < MAG_BITS'(epsilon));
    bbx  = DISC_BITS'(bb);
    ac4  = {ac, 2'b00};
    dneg = 1'b0;
    if ((na2 && ma2 != '0) != (nc2 && mc2 != '0)) begin
      dmag = bbx + ac4;
    end else if (bbx >= ac4) begin
      dmag = bbx - ac4;
    end else begin
      dmag = ac4 - bbx;
      dneg = 1'b1;
    end
    dsmall = (dmag < (DISC_BITS'(epsilon) << FRAC_BITS)) || (dmag == '0);

    sq_in           = '0;
    sq_in.valid     = v2;
    sq_in.rad       = RAD_BITS'(dmag);
    sq_in.ctx.dmag  = {ma2, 1'b0};
    sq_in.ctx.dsign = na2 && ma2 != '0;
    sq_in.ctx.nmag  = mb2;
    sq_in.ctx.nsign = !(nb2 && mb2 != '0) && mb2 != '0;
    if (za) begin
      sq_in.ctx.dmag  = DIV_BITS'(mb2);
      sq_in.ctx.dsign = nb2 && mb2 != '0;
      sq_in.ctx.nmag  = mc2;
      sq_in.ctx.nsign = !(nc2 && mc2 != '0) && mc2 != '0;
      if (zb) begin
        sq_in.ctx.count = zc ? CNT_INF : CNT_NONE;
      end else begin
        sq_in.ctx.count = CNT_ONE;
      end
    end else if (dsmall) begin
      sq_in.ctx.count = CNT_ONE;
    end else if (!dneg) begin
      sq_in.ctx.count = CNT_TWO;
    end else begin
      sq_in.ctx.count = CNT_NONE;
    end
  end

  // square root pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ROOT_BITS; k++) sq[k].valid <= 1'b0;
    end else begin
      sq[0] <= sq_in;
      for (int k = 0; k < ROOT_BITS; k++) sq[k+1] <= sq_step(sq[k]);
    end
  end

  // numerators for both roots
  ctx_t                 cx;
  logic [NUM_BITS:0]    s1, s2;
  dv_stage_t            dv_in;

  always_comb begin
    cx = sq[ROOT_BITS].ctx;
    s1 = sm_add(cx.nsign, NUM_BITS'(cx.nmag), 1'b0, sq[ROOT_BITS].root);
    s2 = sm_add(cx.nsign, NUM_BITS'(cx.nmag), 1'b1, sq[ROOT_BITS].root);
    if (cx.count != CNT_TWO) begin
      s1 = {cx.nsign, NUM_BITS'(cx.nmag)};
      s2 = s1;
    end
    dv_in       = '0;
    dv_in.valid = sq[ROOT_BITS].valid;
    dv_in.count = cx.count;
    dv_in.dmag  = cx.dmag;
    dv_in.neg1  = s1[NUM_BITS] != cx.dsign;
    dv_in.neg2  = s2[NUM_BITS] != cx.dsign;
    dv_in.num1  = {s1[NUM_BITS-1:0], {FRAC_BITS{1'b0}}};
    dv_in.num2  = {s2[NUM_BITS-1:0], {FRAC_BITS{1'b0}}};
  end

  // divider pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QUO_BITS; k++) dv[k].valid <= 1'b0;
    end else begin
      dv[0] <= dv_in;
      for (int k = 0; k < QUO_BITS; k++) dv[k+1] <= dv_step(dv[k]);
    end
  end

  // saturation and output register
  logic [COEF_BITS:0] f1, f2;
  logic               live;
  result_t            result_next;

  always_comb begin
    f1   = sat_root(dv[QUO_BITS].neg1, dv[QUO_BITS].quo1);
    f2   = sat_root(dv[QUO_BITS].neg2, dv[QUO_BITS].quo2);
    live = dv[QUO_BITS].count == CNT_ONE || dv[QUO_BITS].count == CNT_TWO;
    result_next.root_count  = dv[QUO_BITS].count;
    result_next.root_first  = live ? f1[COEF_BITS-1:0] : '0;
    result_next.root_second = live ? f2[COEF_BITS-1:0] : '0;
    result_next.overflow    = live && (f1[COEF_BITS] || f2[COEF_BITS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[QUO_BITS].valid;
    end
    result <= result_next;
  end

endmodule
